// ----- src/timer_pool_scheduler_unit_defines.svh -----
// assertion macros for the timer pool scheduler
// used by the top level; no other dependencies
`ifndef TIMER_POOL_SCHEDULER_UNIT_DEFINES_SVH
`define TIMER_POOL_SCHEDULER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked outside reset
`define TPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TPS_ASSERT(lbl, clk, rst_n, prop, msg)

`define TPS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- src/tps_pkg.sv -----
// shared types and constants of the timer pool scheduler
// no dependencies
`timescale 1ns / 1ps

package tps_pkg;

    localparam int TIME_BITS     = 48;
    localparam int PERIOD_BITS   = 32;
    localparam int COUNT_BITS    = 32;
    localparam int NUM_SLOTS_DEF = 16;

    localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_DEL   = 2'd1;
    localparam logic [1:0] MODE_RUN   = 2'd2;
    localparam logic [1:0] MODE_QUERY = 2'd3;

    localparam logic KIND_FIRE   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic [1:0]             mode;
        logic [3:0]             slot;
        logic [PERIOD_BITS-1:0] period_ms;
        logic                   oneshot;
        logic [TIME_BITS-1:0]   now_ms;
    } t_req;

    typedef struct packed {
        logic                  kind;
        logic [3:0]            fired_slot;
        logic [COUNT_BITS-1:0] fire_count;
        logic [TIME_BITS-1:0]  next_deadline;
        logic                  any_timers;
        logic                  last;
    } t_res;

    // one slot of the timer table as held in memory
    typedef struct packed {
        logic                   oneshot;
        logic [PERIOD_BITS-1:0] period;
        logic [TIME_BITS-1:0]   deadline;
        logic [COUNT_BITS-1:0]  fires;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_REPORT
    } t_state;

endpackage

// ----- src/tps_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module tps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/tps_dl_unit.sv -----
// shared deadline unit: saturating now plus period, and the due compare
// depends on tps_pkg
`timescale 1ns / 1ps

module tps_dl_unit (
    input  logic [tps_pkg::TIME_BITS-1:0]   i_now,
    input  logic [tps_pkg::PERIOD_BITS-1:0] i_period,
    input  logic [tps_pkg::TIME_BITS-1:0]   i_deadline,
    output logic [tps_pkg::TIME_BITS-1:0]   o_sum,
    output logic                            o_due
);

    import tps_pkg::*;

    logic [TIME_BITS:0] full_sum;

    assign full_sum = {1'b0, i_now} + (TIME_BITS + 1)'(i_period);
    // carry out of the time width means the deadline clamps to the top
    assign o_sum    = full_sum[TIME_BITS] ? TMAX : full_sum[TIME_BITS-1:0];
    assign o_due    = (i_now >= i_deadline);

endmodule

// ----- src/timer_pool_scheduler_unit.sv -----
// top level of the timer pool scheduler: sequencer, valid bits, slot table
// depends on tps_pkg, tps_ram, tps_dl_unit, timer_pool_scheduler_unit_defines.svh
//
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------
//  request   | start high, busy low | i_req  (t_req)
//  result    | o_strobe, one cycle  | o_res  (t_res)
//
// busy stays high from the accepting edge through an add state (add requests only), a scan of
// every slot through the slot table's single read port and the one shared deadline unit,
// then one report state.
// fire results come out during the scan in ascending slot order, the report last.
// busy drops in the cycle the report is on the ports, so a new request may be
// taken then; the receiver cannot stall, results are never held.
// synchronous reset clears the valid bits at once; no clearing pass.
`timescale 1ns / 1ps

module timer_pool_scheduler_unit #(
    parameter int NUM_SLOTS = tps_pkg::NUM_SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  tps_pkg::t_req i_req,
    output logic          o_strobe,
    output tps_pkg::t_res o_res
);

    import tps_pkg::*;

    `include "timer_pool_scheduler_unit_defines.svh"

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_SLOTS);

    t_state                r_state,    n_state;
    t_req                  r_req,      n_req;
    logic [CNT_W-1:0]      r_scan_idx, n_scan_idx;
    logic                  r_ev_vld,   n_ev_vld;
    logic [SLOT_W-1:0]     r_ev_idx,   n_ev_idx;
    logic [NUM_SLOTS-1:0]  r_valid,    n_valid;
    logic [TIME_BITS-1:0]  r_min,      n_min;
    logic                  r_any,      n_any;
    logic                  r_out_vld,  n_out_vld;
    t_res                  r_out,      n_out;

    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    t_entry                ram_wdata;
    logic [SLOT_W-1:0]     ram_raddr;
    logic [$bits(t_entry)-1:0] ram_rdata;
    t_entry                rd_entry;

    logic [PERIOD_BITS-1:0] dl_period;
    logic [TIME_BITS-1:0]   dl_sum;
    logic                   dl_due;

    logic                   live;
    logic                   due;
    logic                   keep;
    logic [TIME_BITS-1:0]   cand;
    logic [COUNT_BITS-1:0]  fires_inc;

    assign rd_entry = t_entry'(ram_rdata);

    tps_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (NUM_SLOTS),
        .AW    (SLOT_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // add arms from the request period, the scan re-arms from the stored one
    assign dl_period = (r_state == S_ADD) ? r_req.period_ms : rd_entry.period;

    tps_dl_unit u_dl (
        .i_now      (r_req.now_ms),
        .i_period   (dl_period),
        .i_deadline (rd_entry.deadline),
        .o_sum      (dl_sum),
        .o_due      (dl_due)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ev_vld  <= 1'b0;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ev_vld  <= n_ev_vld;
            r_valid   <= n_valid;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_scan_idx <= n_scan_idx;
        r_ev_idx   <= n_ev_idx;
        r_min      <= n_min;
        r_any      <= n_any;
        r_out      <= n_out;
    end

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_scan_idx = r_scan_idx;
        n_ev_vld   = 1'b0;
        n_ev_idx   = r_ev_idx;
        n_valid    = r_valid;
        n_min      = r_min;
        n_any      = r_any;
        n_out_vld  = 1'b0;
        n_out      = r_out;

        ram_we    = 1'b0;
        ram_waddr = r_ev_idx;
        ram_raddr = r_scan_idx[SLOT_W-1:0];
        ram_wdata = rd_entry;

        live      = r_valid[r_ev_idx];
        due       = live && (r_req.mode == MODE_RUN) && dl_due;
        keep      = live && !(due && rd_entry.oneshot);
        cand      = due ? dl_sum : rd_entry.deadline;
        fires_inc = rd_entry.fires + COUNT_BITS'(1);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req      = i_req;
                    n_scan_idx = '0;
                    n_min      = TMAX;
                    n_any      = 1'b0;
                    if ((i_req.mode == MODE_DEL) && (int'(i_req.slot) < NUM_SLOTS)) begin
                        n_valid[SLOT_W'(i_req.slot)] = 1'b0;
                    end
                    n_state = (i_req.mode == MODE_ADD) ? S_ADD : S_SCAN;
                end
            end
            S_ADD: begin
                if (int'(r_req.slot) < NUM_SLOTS) begin
                    ram_we             = 1'b1;
                    ram_waddr          = SLOT_W'(r_req.slot);
                    ram_wdata.oneshot  = r_req.oneshot;
                    ram_wdata.period   = r_req.period_ms;
                    ram_wdata.deadline = dl_sum;
                    ram_wdata.fires    = '0;
                    n_valid[SLOT_W'(r_req.slot)] = 1'b1;
                end
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // read of the next slot overlaps evaluation of the previous one
                if (r_scan_idx != LAST_CNT) begin
                    n_ev_vld   = 1'b1;
                    n_ev_idx   = r_scan_idx[SLOT_W-1:0];
                    n_scan_idx = r_scan_idx + CNT_W'(1);
                end
                if (r_ev_vld) begin
                    if (due) begin
                        ram_we          = 1'b1;
                        ram_wdata.fires = fires_inc;
                        if (rd_entry.oneshot) begin
                            n_valid[r_ev_idx] = 1'b0;
                        end else begin
                            ram_wdata.deadline = dl_sum;
                        end
                        n_out_vld           = 1'b1;
                        n_out.kind          = KIND_FIRE;
                        n_out.fired_slot    = 4'(r_ev_idx);
                        n_out.fire_count    = fires_inc;
                        n_out.next_deadline = '0;
                        n_out.any_timers    = 1'b0;
                        n_out.last          = 1'b0;
                    end
                    if (keep) begin
                        n_any = 1'b1;
                        if (cand < r_min) begin
                            n_min = cand;
                        end
                    end
                    if (r_scan_idx == LAST_CNT) begin
                        n_state = S_REPORT;
                    end
                end
            end
            S_REPORT: begin
                n_out_vld           = 1'b1;
                n_out.kind          = KIND_REPORT;
                n_out.fired_slot    = '0;
                n_out.fire_count    = '0;
                n_out.next_deadline = r_any ? r_min : '0;
                n_out.any_timers    = r_any;
                n_out.last          = 1'b1;
                n_state             = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_out_vld;
    assign o_res    = r_out;

    `TPS_ASSERT(a_last_is_report, i_clk, i_rst_n,
        o_strobe && o_res.last |-> o_res.kind == KIND_REPORT,
        "last result is not a report")
    `TPS_ASSERT(a_accept_goes_busy, i_clk, i_rst_n,
        start && !busy |=> busy,
        "accepted request did not start work")
    `TPS_ASSERT(a_empty_report_zero, i_clk, i_rst_n,
        o_strobe && o_res.last && !o_res.any_timers |-> o_res.next_deadline == '0,
        "empty table report carries a deadline")
    `TPS_ASSERT(a_report_follows, i_clk, i_rst_n,
        r_state == S_REPORT |=> o_strobe && o_res.last && !busy,
        "report state did not deliver the report")
    `TPS_ASSERT_ALWAYS(a_reset_quiet, i_clk,
        !i_rst_n |=> !o_strobe && !busy,
        "activity right after reset")

endmodule
